@@ rtl/hcr_pkg.sv @@
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared types, widths, register codes and helper functions of the Harris
// corner response block.
// ----------------------------------------------------------------------------
package hcr_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_BLUR_SIZE = 5;

  localparam int PIX_W      = 8;
  localparam int GEO_W      = 13;
  localparam int POS_W      = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int DIM_W      = 12;
  localparam int K_W        = 15;
  localparam int RESP_W     = 41;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 20;
  localparam int XY_W       = 21;
  localparam int PROD_W     = SQ_W + SQ_W + XY_W;
  localparam int TAP_W      = 7;
  localparam int WT_W       = 14;
  localparam int ACC_W      = 38;
  localparam int BLUR_W     = ACC_W - 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K      = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [K_W-1:0]   K_RESET      = 15'd2621;
  localparam logic [RESP_W-1:0] RESP_MAX    = '1;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_ROUTE,
    S_PRD, S_PACC, S_PMUL, S_PWR,
    S_BRD, S_BMUL, S_BACC,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
    S_OUT, S_ADV
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_DECIDE, OP_ROUTE,
    OP_PRD, OP_PACC, OP_PMUL, OP_PWR,
    OP_BRD, OP_BMUL, OP_BACC,
    OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7,
    OP_LOAD, OP_ADV
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic ignore;
    logic do_prod;
    logic border;
    logic do_resp;
    logic ptap_last;
    logic btap_last;
    logic out_free;
  } dp_status_t;

  function automatic int blur_radius(int size);
    int r;
    r = size / 2;
    if (r < 1) r = 1;
    if (r > 3) r = 3;
    return r;
  endfunction

  // Q8 Gaussian taps, d is the distance from the window center
  function automatic logic [TAP_W-1:0] tap_weight(int radius, logic [1:0] d);
    logic [TAP_W-1:0] w;
    w = '0;
    case (radius)
      1: case (d)
           2'd0: w = 7'd98;
           2'd1: w = 7'd79;
           default: w = '0;
         endcase
      2: case (d)
           2'd0: w = 7'd74;
           2'd1: w = 7'd60;
           2'd2: w = 7'd31;
           default: w = '0;
         endcase
      3: case (d)
           2'd0: w = 7'd70;
           2'd1: w = 7'd56;
           2'd2: w = 7'd28;
           default: w = 7'd9;
         endcase
      default: w = '0;
    endcase
    return w;
  endfunction

  // Reflect-101 for x in [-3, n+2], n >= 3
  function automatic logic [GEO_W-1:0] reflect101(logic signed [GEO_W+1:0] x,
                                                   logic [GEO_W-1:0] n);
    logic signed [GEO_W+2:0] p;
    logic signed [GEO_W+2:0] m;
    p = $signed({2'b00, n, 1'b0}) - $signed((GEO_W+3)'(2));
    m = {x[GEO_W+1], x};
    if (m < 0) m = m + p;
    if (m >= p) m = m - p;
    if (m >= $signed({3'b000, n})) m = p - m;
    return m[GEO_W-1:0];
  endfunction

endpackage

@@ rtl/hcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// hcr_ctrl
// Sequencer: walks one item through pixel write, gradient product, blur,
// response arithmetic and output load.
// ----------------------------------------------------------------------------
module hcr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hcr_pkg::dp_status_t status,
  output hcr_pkg::dp_cmd_t   cmd
);
  import hcr_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.op    = OP_DECIDE;
        state_nxt = S_ROUTE;
      end
      S_ROUTE: begin
        cmd.op = OP_ROUTE;
        if (status.ignore) state_nxt = S_IDLE;
        else if (status.do_prod) state_nxt = status.border ? S_PWR : S_PRD;
        else if (status.do_resp) state_nxt = S_BRD;
        else state_nxt = S_ADV;
      end
      S_PRD: begin
        cmd.op    = OP_PRD;
        state_nxt = S_PACC;
      end
      S_PACC: begin
        cmd.op    = OP_PACC;
        state_nxt = status.ptap_last ? S_PMUL : S_PRD;
      end
      S_PMUL: begin
        cmd.op    = OP_PMUL;
        state_nxt = S_PWR;
      end
      S_PWR: begin
        cmd.op    = OP_PWR;
        state_nxt = status.do_resp ? S_BRD : S_ADV;
      end
      S_BRD: begin
        cmd.op    = OP_BRD;
        state_nxt = S_BMUL;
      end
      S_BMUL: begin
        cmd.op    = OP_BMUL;
        state_nxt = S_BACC;
      end
      S_BACC: begin
        cmd.op    = OP_BACC;
        state_nxt = status.btap_last ? S_M1 : S_BRD;
      end
      S_M1: begin
        cmd.op    = OP_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.op    = OP_M2;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.op    = OP_M3;
        state_nxt = S_M4;
      end
      S_M4: begin
        cmd.op    = OP_M4;
        state_nxt = S_M5;
      end
      S_M5: begin
        cmd.op    = OP_M5;
        state_nxt = S_M6;
      end
      S_M6: begin
        cmd.op    = OP_M6;
        state_nxt = S_M7;
      end
      S_M7: begin
        cmd.op    = OP_M7;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        cmd.op    = OP_ADV;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/hcr_dp.sv @@
// ----------------------------------------------------------------------------
// hcr_dp
// Datapath: configuration, raster counters, pixel and product line memories,
// gradient and blur accumulators, response arithmetic and output register.
// ----------------------------------------------------------------------------
module hcr_dp #(
  parameter int MAX_WIDTH = hcr_pkg::DEF_MAX_WIDTH,
  parameter int BLUR_SIZE = hcr_pkg::DEF_BLUR_SIZE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hcr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [hcr_pkg::PIX_W-1:0]        in_pixel,
  input  logic                             in_flush,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [hcr_pkg::RESP_W-1:0]       out_response,
  output logic                             out_frame_end,
  input  hcr_pkg::dp_cmd_t                 cmd,
  output hcr_pkg::dp_status_t              status
);
  import hcr_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RADIUS = blur_radius(BLUR_SIZE);
  localparam int TAPS   = 2 * RADIUS + 1;
  localparam int BI_W   = $clog2(TAPS);

  // configuration
  logic [DIM_W-1:0] width_r, height_r;
  logic [K_W-1:0]   k_r;
  logic             geo_wr;

  assign geo_wr = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      k_r      <= K_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        REG_K:      k_r      <= cfg_wdata[K_W-1:0];
        default: ;
      endcase
    end
  end

  logic [GEO_W-1:0] uw, uh;
  always_comb begin
    if (width_r < DIM_W'(3)) uw = GEO_W'(3);
    else if (int'(width_r) > MAX_WIDTH) uw = GEO_W'(MAX_WIDTH);
    else uw = {1'b0, width_r};
    if (height_r < DIM_W'(3)) uh = GEO_W'(3);
    else uh = {1'b0, height_r};
  end

  logic [POS_W-1:0] total_r, lat_r;
  always_ff @(posedge clk) begin
    total_r <= POS_W'(uw * uh);
    lat_r   <= POS_W'((RADIUS + 1) * int'(uw) + RADIUS + 1);
  end

  // raster counters
  logic [GEO_W-1:0] col_r, row_r;
  logic [POS_W-1:0] t_r;
  logic             last_r;

  always_ff @(posedge clk) begin
    if (!rst_n || geo_wr) begin
      col_r <= '0;
      row_r <= '0;
      t_r   <= '0;
    end else if (cmd.op == OP_ADV) begin
      if (last_r) begin
        col_r <= '0;
        row_r <= '0;
        t_r   <= '0;
      end else begin
        t_r <= t_r + POS_W'(1);
        if (col_r + GEO_W'(1) >= uw) begin
          col_r <= '0;
          row_r <= row_r + GEO_W'(1);
        end else begin
          col_r <= col_r + GEO_W'(1);
        end
      end
    end
  end

  // input capture
  logic [PIX_W-1:0] pixel_r;
  logic             flush_r;
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) begin
      pixel_r <= in_pixel;
      flush_r <= in_flush;
    end
  end

  // per-item decisions
  logic                    taking;
  logic [POS_W-1:0]        wp1;
  logic                    prod_ok, resp_ok, last_c, border_c;
  logic [GEO_W-1:0]        gr_c, gc_c, or_c;
  logic signed [GEO_W+1:0] oc_c;

  always_comb begin
    taking  = row_r < uh;
    wp1     = POS_W'(uw) + POS_W'(1);
    prod_ok = (t_r >= wp1) && ((t_r - wp1) < total_r);
    resp_ok = t_r >= lat_r;
    last_c  = (t_r - lat_r) >= (total_r - POS_W'(1));
    if (col_r == '0) begin
      gc_c = uw - GEO_W'(1);
      gr_c = row_r - GEO_W'(2);
    end else begin
      gc_c = col_r - GEO_W'(1);
      gr_c = row_r - GEO_W'(1);
    end
    border_c = (gr_c == '0) || (gc_c == '0) || (gr_c == uh - GEO_W'(1)) ||
               (gc_c == uw - GEO_W'(1));
    // borrow whole rows until the column is back in range
    oc_c = $signed({2'b00, col_r}) - $signed((GEO_W+2)'(RADIUS + 1));
    or_c = row_r - GEO_W'(RADIUS + 1);
    if (oc_c < 0) begin
      oc_c = oc_c + $signed({2'b00, uw});
      or_c = or_c - GEO_W'(1);
    end
    if (oc_c < 0) begin
      oc_c = oc_c + $signed({2'b00, uw});
      or_c = or_c - GEO_W'(1);
    end
  end

  logic             ignore_r, do_prod_r, border_r, do_resp_r;
  logic [GEO_W-1:0] gr_r, gc_r, orow_r, ocol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_r  <= 1'b0;
      do_prod_r <= 1'b0;
      border_r  <= 1'b0;
      do_resp_r <= 1'b0;
      last_r    <= 1'b0;
    end else if (cmd.op == OP_DECIDE) begin
      ignore_r  <= taking && flush_r;
      do_prod_r <= prod_ok;
      border_r  <= border_c;
      do_resp_r <= resp_ok;
      last_r    <= resp_ok && last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DECIDE) begin
      gr_r   <= gr_c;
      gc_r   <= gc_c;
      orow_r <= or_c;
      ocol_r <= oc_c[GEO_W-1:0];
    end
  end

  // pixel line memory
  logic [PIX_W-1:0] pix_mem [0:(4 << CW)-1];
  logic [PIX_W-1:0] pix_rd_r;
  logic [1:0]       pty_r, ptx_r;
  logic [1:0]       prow;
  logic [GEO_W-1:0] pcol;

  assign prow = gr_r[1:0] + 2'd3 + pty_r;
  assign pcol = gc_r + GEO_W'(ptx_r) - GEO_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DECIDE && taking && !flush_r) begin
      pix_mem[{row_r[1:0], col_r[CW-1:0]}] <= pixel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PRD) begin
      pix_rd_r <= pix_mem[{prow, pcol[CW-1:0]}];
    end
  end

  // gradient accumulation over the 3x3 neighborhood
  logic signed [GRAD_W-1:0] v_r, k_r_grad;
  logic signed [GRAD_W-1:0] pix_s;
  assign pix_s = $signed({{(GRAD_W-PIX_W){1'b0}}, pix_rd_r});

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ROUTE) begin
      v_r      <= '0;
      k_r_grad <= '0;
      pty_r    <= '0;
      ptx_r    <= '0;
    end else if (cmd.op == OP_PACC) begin
      if (pty_r == 2'd0) v_r <= v_r + pix_s;
      else if (pty_r == 2'd2) v_r <= v_r - pix_s;
      if (ptx_r == 2'd0) k_r_grad <= k_r_grad + pix_s;
      else if (ptx_r == 2'd2) k_r_grad <= k_r_grad - pix_s;
      if (ptx_r == 2'd2) begin
        ptx_r <= '0;
        pty_r <= pty_r + 2'd1;
      end else begin
        ptx_r <= ptx_r + 2'd1;
      end
    end
  end

  logic [SQ_W-1:0]        gx_r, gy_r;
  logic signed [XY_W-1:0] gxy_r;
  logic signed [2*GRAD_W-1:0] vv, kk, kv;
  assign vv = v_r * v_r;
  assign kk = k_r_grad * k_r_grad;
  assign kv = k_r_grad * v_r;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PMUL) begin
      gx_r  <= vv[SQ_W-1:0];
      gy_r  <= kk[SQ_W-1:0];
      gxy_r <= kv[XY_W-1:0];
    end
  end

  // product line memory
  logic [PROD_W-1:0] prod_mem [0:(8 << CW)-1];
  logic [PROD_W-1:0] prod_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PWR) begin
      prod_mem[{gr_r[2:0], gc_r[CW-1:0]}] <= border_r ? '0 : {gxy_r, gy_r, gx_r};
    end
  end

  // blur window addressing
  logic [BI_W-1:0]         bdy_r, bdx_r, ddy, ddx;
  logic signed [GEO_W+1:0] brow_x, bcol_x;
  logic [GEO_W-1:0]        brr, bcc;
  logic [WT_W-1:0]         wt_c, wt_r;

  always_comb begin
    brow_x = $signed({2'b00, orow_r}) + $signed({{(GEO_W+2-BI_W){1'b0}}, bdy_r})
           - $signed((GEO_W+2)'(RADIUS));
    bcol_x = $signed({2'b00, ocol_r}) + $signed({{(GEO_W+2-BI_W){1'b0}}, bdx_r})
           - $signed((GEO_W+2)'(RADIUS));
    brr = reflect101(brow_x, uh);
    bcc = reflect101(bcol_x, uw);
    ddy = (bdy_r >= BI_W'(RADIUS)) ? bdy_r - BI_W'(RADIUS) : BI_W'(RADIUS) - bdy_r;
    ddx = (bdx_r >= BI_W'(RADIUS)) ? bdx_r - BI_W'(RADIUS) : BI_W'(RADIUS) - bdx_r;
    wt_c = WT_W'(tap_weight(RADIUS, 2'(ddy)) * tap_weight(RADIUS, 2'(ddx)));
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_BRD) begin
      prod_rd_r <= prod_mem[{brr[2:0], bcc[CW-1:0]}];
      wt_r      <= wt_c;
    end
  end

  logic [WT_W+SQ_W-1:0]         mx_r, my_r;
  logic signed [WT_W+XY_W:0]    mxy_r;
  always_ff @(posedge clk) begin
    if (cmd.op == OP_BMUL) begin
      mx_r  <= wt_r * prod_rd_r[SQ_W-1:0];
      my_r  <= wt_r * prod_rd_r[2*SQ_W-1:SQ_W];
      mxy_r <= $signed({1'b0, wt_r}) * $signed(prod_rd_r[PROD_W-1:2*SQ_W]);
    end
  end

  logic signed [ACC_W-1:0] accx_r, accy_r, accxy_r;
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ROUTE) begin
      accx_r  <= '0;
      accy_r  <= '0;
      accxy_r <= '0;
      bdy_r   <= '0;
      bdx_r   <= '0;
    end else if (cmd.op == OP_BACC) begin
      accx_r  <= accx_r + $signed({{(ACC_W-WT_W-SQ_W){1'b0}}, mx_r});
      accy_r  <= accy_r + $signed({{(ACC_W-WT_W-SQ_W){1'b0}}, my_r});
      accxy_r <= accxy_r + ACC_W'(mxy_r);
      if (bdx_r == BI_W'(TAPS - 1)) begin
        bdx_r <= '0;
        bdy_r <= bdy_r + BI_W'(1);
      end else begin
        bdx_r <= bdx_r + BI_W'(1);
      end
    end
  end

  // response arithmetic
  logic signed [ACC_W-1:0]    rx, ry, rxy;
  logic signed [BLUR_W-1:0]   bx_r, by_r, bxy_r;
  logic signed [2*BLUR_W-1:0] p1_r, p2_r;
  logic [BLUR_W-1:0]          tr_r;
  logic signed [2*BLUR_W:0]   det_r;
  logic [2*BLUR_W-1:0]        tr2_r;
  logic [K_W+BLUR_W-1:0]      kl_r, kh_r;
  logic [K_W+2*BLUR_W-1:0]    ktsum;
  logic [K_W+2*BLUR_W-17:0]   kt_r;
  logic signed [2*BLUR_W+1:0] res_r;
  logic [2*BLUR_W+1:0]        mag;
  logic [RESP_W-1:0]          resp_r;

  assign rx  = accx_r  + $signed(ACC_W'(32768));
  assign ry  = accy_r  + $signed(ACC_W'(32768));
  assign rxy = accxy_r + $signed(ACC_W'(32768));
  assign ktsum = {kh_r, {BLUR_W{1'b0}}} + (K_W+2*BLUR_W)'(kl_r)
               + (K_W+2*BLUR_W)'(32768);
  assign mag = res_r[2*BLUR_W+1] ? (2*BLUR_W+2)'(-res_r) : res_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_M1: begin
        bx_r  <= rx[ACC_W-1:16];
        by_r  <= ry[ACC_W-1:16];
        bxy_r <= rxy[ACC_W-1:16];
      end
      OP_M2: begin
        p1_r <= bx_r * by_r;
        p2_r <= bxy_r * bxy_r;
        tr_r <= BLUR_W'(bx_r + by_r);
      end
      OP_M3: begin
        det_r <= p1_r - p2_r;
        tr2_r <= tr_r * tr_r;
      end
      OP_M4: begin
        kl_r <= k_r * tr2_r[BLUR_W-1:0];
        kh_r <= k_r * tr2_r[2*BLUR_W-1:BLUR_W];
      end
      OP_M5: kt_r <= ktsum[K_W+2*BLUR_W-1:16];
      OP_M6: res_r <= det_r - $signed({2'b00, kt_r});
      OP_M7: resp_r <= (mag > (2*BLUR_W+2)'(RESP_MAX)) ? RESP_MAX : mag[RESP_W-1:0];
      default: ;
    endcase
  end

  // output register
  logic              out_valid_r;
  logic [RESP_W-1:0] out_response_r;
  logic              out_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      out_response_r  <= resp_r;
      out_frame_end_r <= last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_response  = out_response_r;
  assign out_frame_end = out_frame_end_r;

  assign status.ignore    = ignore_r;
  assign status.do_prod   = do_prod_r;
  assign status.border    = border_r;
  assign status.do_resp   = do_resp_r;
  assign status.ptap_last = (pty_r == 2'd2) && (ptx_r == 2'd2);
  assign status.btap_last = (bdy_r == BI_W'(TAPS - 1)) && (bdx_r == BI_W'(TAPS - 1));
  assign status.out_free  = !out_valid_r || !out_stall;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_LOAD |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending result");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_LOAD |=> out_valid_r)
    else $error("loaded result not presented");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < uw)
    else $error("column counter past row width");

endmodule

@@ rtl/harris_corner_response.sv @@
// ----------------------------------------------------------------------------
// harris_corner_response
// Streaming Harris corner response over a raster of grayscale pixels.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item with neither gradient product nor
// result is accepted, decided, routed and advanced; a flush item inside the
// frame is dropped after routing. An interior product takes 9 reads of the
// single-port pixel line memory, each with an accumulate, then multiply and
// write; a border product is written as zero. A result adds (2R+1)^2 reads
// of the product line memory's one read port (R = 2 by default), each with a
// multiply and accumulate, then the response math and any wait for the output
// register. The next item is taken while the previous result waits there. The
// result for position o comes with the item at o + (R+1)*W + R + 1; flush
// items drain the last rows. Writing the width or height restarts the frame.
module harris_corner_response #(
  parameter int MAX_WIDTH = hcr_pkg::DEF_MAX_WIDTH,
  parameter int BLUR_SIZE = hcr_pkg::DEF_BLUR_SIZE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hcr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hcr_pkg::PIX_W-1:0]      in_pixel,
  input  logic                           in_flush,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hcr_pkg::RESP_W-1:0]     out_response,
  output logic                           out_frame_end
);
  import hcr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  hcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  hcr_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .BLUR_SIZE (BLUR_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_pixel      (in_pixel),
    .in_flush      (in_flush),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_response  (out_response),
    .out_frame_end (out_frame_end),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

@@ sim/hcr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcr_checker
// Watches the pixel, result and register ports of harris_corner_response.
// It keeps its own raster state, forms the expected corner strength of every
// position and compares each result transfer with the oldest expected one.
// ----------------------------------------------------------------------------
module hcr_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hcr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [hcr_pkg::PIX_W-1:0]      in_pixel,
  input  logic                           in_flush,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [hcr_pkg::RESP_W-1:0]     out_response,
  input  logic                           out_frame_end,
  output int                             fail_count,
  output int                             results_due,
  output int                             results_seen
);
  import hcr_pkg::*;

  localparam int LINE_MAX = 2048;
  localparam int RAD      = 2;

  typedef struct {
    logic [RESP_W-1:0] strength;
    logic              frame_end;
  } corner_t;

  corner_t corner_q[$];

  logic [PIX_W-1:0] pix_line [4][LINE_MAX];
  longint           grad_prod [8][LINE_MAX][3];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [K_W-1:0]   k_reg;
  int unsigned      col_pos;
  int unsigned      row_pos;

  const int blur_tap [3] = '{74, 60, 31};

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h < 3) h = 3;
    return h;
  endfunction

  function automatic int unsigned mirror(longint x, int unsigned n);
    longint p;
    longint m;
    p = 2 * longint'(n) - 2;
    m = x % p;
    if (m < 0) m += p;
    if (m >= n) m = p - m;
    return int'(m);
  endfunction

  // Unscaled 3x3 row/column differences and their three products
  task automatic form_gradients(int unsigned g, int unsigned w, int unsigned h);
    int unsigned gr;
    int unsigned gc;
    int unsigned u;
    int unsigned m;
    int unsigned d;
    longint v;
    longint k;
    gr = g / w;
    gc = g % w;
    if (gr == 0 || gc == 0 || gr == h - 1 || gc == w - 1) begin
      grad_prod[gr % 8][gc] = '{0, 0, 0};
      return;
    end
    u = (gr - 1) % 4;
    m = gr % 4;
    d = (gr + 1) % 4;
    v = longint'(pix_line[u][gc-1]) + pix_line[u][gc] + pix_line[u][gc+1]
      - pix_line[d][gc-1] - pix_line[d][gc] - pix_line[d][gc+1];
    k = longint'(pix_line[u][gc-1]) + pix_line[m][gc-1] + pix_line[d][gc-1]
      - pix_line[u][gc+1] - pix_line[m][gc+1] - pix_line[d][gc+1];
    grad_prod[gr % 8][gc] = '{v * v, k * k, k * v};
  endtask

  function automatic logic [RESP_W-1:0] corner_strength(int unsigned o, int unsigned w,
                                                        int unsigned h);
    longint sum [3];
    longint blur [3];
    longint wt;
    longint det;
    longint tr;
    longint kt;
    longint diff;
    int unsigned rr;
    int unsigned cc;
    sum = '{0, 0, 0};
    for (int dy = -RAD; dy <= RAD; dy++) begin
      rr = mirror(longint'(o / w) + dy, h);
      for (int dx = -RAD; dx <= RAD; dx++) begin
        cc = mirror(longint'(o % w) + dx, w);
        wt = blur_tap[dy < 0 ? -dy : dy] * blur_tap[dx < 0 ? -dx : dx];
        for (int p = 0; p < 3; p++) sum[p] += wt * grad_prod[rr % 8][cc][p];
      end
    end
    for (int p = 0; p < 3; p++) blur[p] = (sum[p] + 32768) >>> 16;
    det = blur[0] * blur[1] - blur[2] * blur[2];
    tr = blur[0] + blur[1];
    kt = (longint'(k_reg) * (tr * tr) + 32768) >>> 16;
    diff = det - kt;
    if (diff < 0) diff = -diff;
    if (diff > longint'(RESP_MAX)) return RESP_MAX;
    return diff[RESP_W-1:0];
  endfunction

  task automatic take_pixel(logic [PIX_W-1:0] pixel, logic flush);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned lat;
    int unsigned t;
    bit taking;
    bit last;
    corner_t c;
    w = eff_width();
    h = eff_height();
    total = w * h;
    lat = (RAD + 1) * w + RAD + 1;
    t = row_pos * w + col_pos;
    taking = row_pos < h;
    last = 0;
    // a flush before the frame is complete is dropped
    if (taking && flush) return;
    if (taking) pix_line[row_pos % 4][col_pos] = pixel;
    if (t >= w + 1 && t - (w + 1) < total) form_gradients(t - (w + 1), w, h);
    if (t >= lat) begin
      last = (t - lat) >= total - 1;
      c.strength = corner_strength(t - lat, w, h);
      c.frame_end = last;
      corner_q.push_back(c);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (last) begin
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic report(string what, logic [RESP_W-1:0] want, logic [RESP_W-1:0] got);
    $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    corner_t c;
    if (!rst_n) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      k_reg = K_RESET;
      col_pos = 0;
      row_pos = 0;
      corner_q.delete();
      fail_count = 0;
      results_seen <= 0;
      results_due <= 0;
      foreach (grad_prod[i, j]) grad_prod[i][j] = '{0, 0, 0};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH, REG_HEIGHT: begin
            if (cfg_index == REG_WIDTH) width_reg = cfg_wdata[DIM_W-1:0];
            else height_reg = cfg_wdata[DIM_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          REG_K: k_reg = cfg_wdata[K_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_pixel(in_pixel, in_flush);
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (corner_q.size() == 0) begin
          report("unexpected result", '0, out_response);
        end else begin
          c = corner_q.pop_front();
          if (out_response !== c.strength) report("response", c.strength, out_response);
          if (out_frame_end !== c.frame_end)
            report("frame_end", RESP_W'(c.frame_end), RESP_W'(out_frame_end));
        end
      end
      results_due <= corner_q.size();
    end
  end

endmodule

@@ sim/tb_harris_corner_response.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_harris_corner_response
// Feeds small frames of pixels through harris_corner_response under several
// geometries and weights, with bursty input, a stalling output and one long
// output hold-off; hcr_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_harris_corner_response;
  import hcr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int ITEM_TARGET = 1150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel = '0;
  logic                  in_flush = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RESP_W-1:0]     out_response;
  logic                  out_frame_end;
  int                    fail_count;
  int                    results_due;
  int                    results_seen;

  int items_sent = 0;
  int frames_run = 0;
  int burst_left = 0;
  int cycle_no = 0;

  always #5 clk = ~clk;

  harris_corner_response dut (.*);

  hcr_checker u_checker (.*);

  // receiver: changing stall patterns plus one long hold-off
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= 40000 && cycle_no < 43000) out_stall <= 1'b1;
    else case ((cycle_no / 700) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 4);
      default: out_stall <= ((cycle_no % 11) < 5);
    endcase
  end

  task automatic send_item(logic [PIX_W-1:0] pixel, logic flush);
    in_valid <= 1'b1;
    in_pixel <= pixel;
    in_flush <= flush;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // hold the input quiet until every result is out and the block has settled
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_due == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] make_pixel(int style, int unsigned pos);
    case (style)
      0: return PIX_W'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return PIX_W'(pos * 23 + $urandom_range(0, 15));
    endcase
  endfunction

  // full frame followed by the drain; draining items are flush or pixel
  task automatic run_frame(int unsigned w, int unsigned h, int style);
    int unsigned lat;
    lat = 3 * w + 3;
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(PIX_W'($urandom_range(0, 255)), 1'b1);
      send_item(make_pixel(style, i), 1'b0);
    end
    for (int unsigned i = 0; i < lat; i++)
      send_item(PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    frames_run++;
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest frame with clamped geometry and the largest weight
    write_reg(REG_WIDTH, 15'd1);
    write_reg(REG_HEIGHT, 15'd2);
    write_reg(REG_K, 15'h7FFF);
    write_reg(REG_SPARE, 15'h5A5A);
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b1);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd128, 1'b0);
    for (int i = 0; i < 12; i++) send_item(8'hA5, i[0]);
    settle();

    // widest line, abandoned early by a geometry write
    write_reg(REG_WIDTH, 15'd2048);
    write_reg(REG_HEIGHT, 15'd3);
    for (int i = 0; i < 30; i++) send_item(PIX_W'($urandom_range(0, 255)), 1'b0);
    settle();
    write_reg(REG_HEIGHT, 15'd4095);
    write_reg(REG_WIDTH, 15'h7FFF);

    // small frame abandoned after some results
    write_reg(REG_WIDTH, 15'd5);
    write_reg(REG_HEIGHT, 15'd6);
    write_reg(REG_K, 15'd0);
    for (int i = 0; i < 26; i++) send_item(PIX_W'($urandom_range(0, 255)), 1'b0);
    settle();
    write_reg(REG_HEIGHT, 15'd4);
    run_frame(5, 4, 1);
    settle();

    while (items_sent < ITEM_TARGET) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      write_reg(REG_WIDTH, CFG_DATA_W'(w) | CFG_DATA_W'($urandom_range(0, 7) << 12));
      write_reg(REG_HEIGHT, CFG_DATA_W'(h) | CFG_DATA_W'($urandom_range(0, 7) << 12));
      case ($urandom_range(0, 5))
        0: write_reg(REG_K, 15'd0);
        1: write_reg(REG_K, 15'd16384);
        2: write_reg(REG_K, 15'h7FFF);
        3: write_reg(REG_K, 15'd2621);
        default: write_reg(REG_K, CFG_DATA_W'($urandom_range(0, 32767)));
      endcase
      if (w < 3) w = 3;
      if (h < 3) h = 3;
      run_frame(w, h, $urandom_range(0, 2));
      settle();
    end

    $display("Ran %0d frames, %0d pixel/flush transfers, %0d results checked.",
             frames_run, items_sent, results_seen);
    $display("Geometries 3x3 to 10x8 plus clamped, abandoned and 2048-wide setups.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
